/* rtl/core/tlb_fifo_replacement_defines.svh */
// ----------------------------------------------------------------------------
// tlb_fifo_replacement assertion macros
// Shared concurrent assertion wrappers for the translation buffer RTL.
// ----------------------------------------------------------------------------
`ifndef TLB_FIFO_REPLACEMENT_DEFINES_SVH
`define TLB_FIFO_REPLACEMENT_DEFINES_SVH

// clocked assertion, muted while reset is asserted
`define TLBF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, checked during reset as well
`define TLBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tlbf_pkg.sv */
// ----------------------------------------------------------------------------
// tlbf_pkg
// Types and constants of the FIFO-replacement translation buffer.
// ----------------------------------------------------------------------------
package tlbf_pkg;

  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 15;
  localparam int SLOT_W  = 4;

  typedef enum logic {
    FUNC_LOOKUP = 1'b0,
    FUNC_ADD    = 1'b1
  } func_e;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
    slot_t  match_slot;
    slot_t  victim_slot;
  } cam_res_t;

endpackage

/* rtl/core/tlbf_cam.sv */
// ----------------------------------------------------------------------------
// tlbf_cam
// Entry storage, parallel page match and FIFO victim selection.
// ----------------------------------------------------------------------------
module tlbf_cam #(
  parameter int ENTRIES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlbf_pkg::page_t   page_i,
  input  logic              wr_en_i,
  input  tlbf_pkg::frame_t  wr_frame_i,
  output tlbf_pkg::cam_res_t res_o
);
  import tlbf_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  page_t  page_q  [ENTRIES];
  frame_t frame_q [ENTRIES];

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] oldest_q, oldest_d;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [IDX_W-1:0]   match_idx;
  frame_t             match_frame;
  logic               full;
  logic [IDX_W-1:0]   wr_idx;

  logic [IDX_W+SLOT_W-1:0] match_ext;
  logic [IDX_W+SLOT_W-1:0] victim_ext;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CNT_W'(i) < fill_q) && (page_q[i] == page_i);
    end
  end

  // isolate lowest set bit
  assign first = match & (~match + ENTRIES'(1));

  always_comb begin
    match_idx   = '0;
    match_frame = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first[i]) begin
        match_idx   = match_idx | IDX_W'(i);
        match_frame = match_frame | frame_q[i];
      end
    end
  end

  assign full   = (fill_q == CNT_W'(ENTRIES));
  assign wr_idx = full ? oldest_q : fill_q[IDX_W-1:0];

  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (wr_en_i) begin
      if (full) begin
        oldest_d = (oldest_q == IDX_W'(ENTRIES - 1)) ? '0 : oldest_q + IDX_W'(1);
      end else begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
    end else begin
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      page_q[wr_idx]  <= page_i;
      frame_q[wr_idx] <= wr_frame_i;
    end
  end

  assign match_ext  = {{SLOT_W{1'b0}}, match_idx};
  assign victim_ext = {{SLOT_W{1'b0}}, wr_idx};

  assign res_o.hit         = |match;
  assign res_o.frame       = match_frame;
  assign res_o.match_slot  = match_ext[SLOT_W-1:0];
  assign res_o.victim_slot = victim_ext[SLOT_W-1:0];

endmodule

/* rtl/core/tlb_fifo_replacement.sv */
// ----------------------------------------------------------------------------
// tlb_fifo_replacement
// Fully associative translation buffer with first-in first-out replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid_i / in_stall_o with func_i, page_number_i,
//   new_frame_i. A lookup (FUNC_LOOKUP) returns hit_o, found_frame_o and the
//   matching slot_o; an add (FUNC_ADD) fills the lowest empty entry, or the
//   oldest one once all ENTRIES are in use, and returns the written slot_o.
//   Result channel: out_valid_o / out_stall_i, one result per request.
//   out_valid_o comes from the result register, which is loaded from the
//   request register. Throughput: one request per clock unless a result
//   stalls; compare, priority pick and entry write happen between the two.
//   Reset empties the buffer and clears the replacement pointer; no
//   initialization sweep, requests are taken right after reset.
//   A stalled result holds; the request register then holds one more
//   request and in_stall_o is raised until the result is taken.
// ----------------------------------------------------------------------------
`include "tlb_fifo_replacement_defines.svh"

module tlb_fifo_replacement #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  tlbf_pkg::page_t  page_number_i,
  input  tlbf_pkg::frame_t new_frame_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o,
  output tlbf_pkg::frame_t found_frame_o,
  output tlbf_pkg::slot_t  slot_o
);
  import tlbf_pkg::*;

  logic   req_valid_q;
  logic   req_func_q;
  page_t  req_page_q;
  frame_t req_frame_q;

  logic   out_valid_q;
  logic   out_hit_q, out_hit_d;
  frame_t out_frame_q, out_frame_d;
  slot_t  out_slot_q, out_slot_d;

  logic     out_free;
  logic     advance;
  logic     in_take;
  logic     is_add;
  cam_res_t cam_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = req_valid_q && out_free;
  assign in_stall_o = req_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign is_add     = (req_func_q == FUNC_ADD);

  tlbf_cam #(
    .ENTRIES(ENTRIES)
  ) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .page_i     (req_page_q),
    .wr_en_i    (advance && is_add),
    .wr_frame_i (req_frame_q),
    .res_o      (cam_res)
  );

  always_comb begin
    out_hit_d   = 1'b0;
    out_frame_d = '0;
    out_slot_d  = cam_res.victim_slot;
    if (!is_add) begin
      out_hit_d   = cam_res.hit;
      out_frame_d = cam_res.frame;
      out_slot_d  = cam_res.match_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_func_q  <= func_i;
      req_page_q  <= page_number_i;
      req_frame_q <= new_frame_i;
    end
    if (advance) begin
      out_hit_q   <= out_hit_d;
      out_frame_q <= out_frame_d;
      out_slot_q  <= out_slot_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign found_frame_o = out_frame_q;
  assign slot_o        = out_slot_q;

  `TLBF_ASSERT(a_take_loads_req, clk_i, rst_ni, in_take |=> req_valid_q, "accepted request lost")
  `TLBF_ASSERT(a_add_no_hit, clk_i, rst_ni, (advance && is_add) |=> (out_valid_o && !hit_o && found_frame_o == '0), "add result reports a hit")
  `TLBF_ASSERT_ALWAYS(a_stall_needs_req, clk_i, in_stall_o |-> (req_valid_q && out_valid_q), "stall without pending request")

endmodule
